// ===== sv/perceptron_classify_train_unit_defines.svh =====
// Assertion macros for the checker file.
`ifndef PERCEPTRON_CLASSIFY_TRAIN_UNIT_DEFINES_SVH
`define PERCEPTRON_CLASSIFY_TRAIN_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define PCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define PCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pct_pkg.sv =====
package pct_pkg;

	// Field widths of the stream words.
	localparam int CMD_W   = 2;
	localparam int IDX_W   = 10;
	localparam int W_W     = 24;
	localparam int PIX_W   = 8;
	localparam int GAMMA_W = 16;
	localparam int ACC_W   = 42;
	localparam int PROD_W  = W_W + PIX_W + 1;
	localparam int DELTA_W = 16;

	// Learning rate after reset, about 0.01 in Q0.16.
	localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd655;

	// Output queue depth; it also bounds the items in flight.
	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
	localparam int OFIFO_CW    = OFIFO_AW + 1;

	// Result kinds carried on the output tuser.
	localparam logic KIND_DECISION = 1'b0;
	localparam logic KIND_READBACK = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE    = 2'd0,
		CMD_CLASSIFY = 2'd1,
		CMD_TRAIN    = 2'd2,
		CMD_READ     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		SW_IDLE  = 2'd0,
		SW_RUN   = 2'd1,
		SW_DRAIN = 2'd2
	} sweep_state_t;

	typedef struct packed {
		logic                  mistake;
		logic                  predicted_positive;
		logic signed [W_W-1:0] read_weight;
		logic                  result_kind;
	} res_t;

	// Status from the accumulate pipeline to the rest of the block.
	typedef struct packed {
		logic hold;
		logic start;
		logic positive;
	} mac_stat_t;

	// Control from the update sequencer to the weight memory.
	typedef struct packed {
		logic busy;
		logic rd_en;
		logic wr_en;
	} sweep_ctl_t;

endpackage

// ===== sv/pct_mac.sv =====
module pct_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  pct_pkg::cmd_t                 in_cmd,
	input  logic [pct_pkg::PIX_W-1:0]     in_pixel,
	input  logic                          in_target,
	input  logic                          in_last,
	input  logic                          in_range,
	input  logic signed [pct_pkg::W_W-1:0] w_rdata,
	output logic                          push,
	output pct_pkg::res_t                 res,
	output pct_pkg::mac_stat_t            stat,
	output logic [1:0]                    inflight
);
	import pct_pkg::*;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	logic                    v_s1, v_s2;
	cmd_t                    cmd_s1, cmd_s2;
	logic [PIX_W-1:0]        pix_s1;
	logic                    tgt_s1, tgt_s2;
	logic                    last_s1, last_s2;
	logic                    rng_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [W_W-1:0]   rw_s2;
	logic signed [ACC_W-1:0] dot_sum_q;

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W:0]   sum;
	logic signed [ACC_W-1:0] acc_sat;
	logic                    is_end;
	logic                    pred;
	logic                    miss;

	// Stage 1 holds the item while the weight memory answers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= in_cmd;
		pix_s1  <= in_pixel;
		tgt_s1  <= in_target;
		last_s1 <= in_last;
		rng_s1  <= in_range;
	end

	// Weight times pixel; an out-of-range position or a readback adds nothing.
	always_comb begin
		prod = w_rdata * $signed({1'b0, pix_s1});
		if (!rng_s1 || cmd_s1 == CMD_READ) begin
			prod = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod;
		rw_s2   <= rng_s1 ? w_rdata : '0;
		cmd_s2  <= cmd_s1;
		tgt_s2  <= tgt_s1;
		last_s2 <= last_s1;
	end

	// Saturating accumulate and the decision on the final pixel.
	always_comb begin
		sum = (ACC_W+1)'(dot_sum_q) + (ACC_W+1)'(prod_s2);
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			acc_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sat = sum[ACC_W-1:0];
		end
		is_end = v_s2 && last_s2 && cmd_s2 != CMD_READ;
		pred   = ~acc_sat[ACC_W-1];
		miss   = (cmd_s2 == CMD_TRAIN) && (pred != tgt_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_sum_q <= '0;
		end else if (v_s2) begin
			dot_sum_q <= is_end ? '0 : acc_sat;
		end
	end

	// Result word and status for the update sequencer.
	always_comb begin
		push = v_s2 && (cmd_s2 == CMD_READ || is_end);
		if (cmd_s2 == CMD_READ) begin
			res.result_kind        = KIND_READBACK;
			res.read_weight        = rw_s2;
			res.predicted_positive = 1'b0;
			res.mistake            = 1'b0;
		end else begin
			res.result_kind        = KIND_DECISION;
			res.read_weight        = '0;
			res.predicted_positive = pred;
			res.mistake            = miss;
		end
		stat.hold     = (v_s1 && last_s1 && cmd_s1 == CMD_TRAIN) ||
		                (v_s2 && last_s2 && cmd_s2 == CMD_TRAIN);
		stat.start    = is_end && miss;
		stat.positive = tgt_s2;
		inflight      = {1'b0, v_s1} + {1'b0, v_s2};
	end

endmodule

// ===== sv/pct_sweep.sv =====
module pct_sweep #(
	parameter int NUM_PIXELS = 784,
	parameter int AW         = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            positive,
	input  logic [pct_pkg::GAMMA_W-1:0]     gamma,
	input  logic signed [pct_pkg::W_W-1:0]  w_rdata,
	input  logic [pct_pkg::PIX_W-1:0]       i_rdata,
	output pct_pkg::sweep_ctl_t             ctl,
	output logic [AW-1:0]                   rd_addr,
	output logic [AW-1:0]                   wr_addr,
	output logic signed [pct_pkg::W_W-1:0]  wr_data
);
	import pct_pkg::*;

	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PIXELS - 1);
	localparam logic signed [W_W-1:0] W_MAX = {1'b0, {(W_W-1){1'b1}}};
	localparam logic signed [W_W-1:0] W_MIN = {1'b1, {(W_W-1){1'b0}}};
	localparam int SCALE_W = GAMMA_W + PIX_W;

	sweep_state_t state_q, state_next;
	logic [AW-1:0]          cnt_q;
	logic                   positive_q;
	logic                   v_u1, v_u2;
	logic [AW-1:0]          a_u1, a_u2;
	logic [DELTA_W-1:0]     delta_u2;
	logic signed [W_W-1:0]  w_u2;

	logic [SCALE_W-1:0]     scaled;
	logic signed [W_W:0]    upd;

	// Next state of the sweep sequencer.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			SW_IDLE: begin
				if (start) state_next = SW_RUN;
			end
			SW_RUN: begin
				if (cnt_q == LAST_ADDR) state_next = SW_DRAIN;
			end
			SW_DRAIN: begin
				if (!v_u1 && !v_u2) state_next = SW_IDLE;
			end
			default: state_next = SW_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		ctl.busy  = 1'b1;
		ctl.rd_en = 1'b0;
		unique case (state_q)
			SW_IDLE:  ctl.busy  = 1'b0;
			SW_RUN:   ctl.rd_en = 1'b1;
			SW_DRAIN: ctl.rd_en = 1'b0;
			default:  ctl.busy  = 1'b0;
		endcase
		ctl.wr_en = v_u2;
		rd_addr   = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SW_IDLE;
			cnt_q   <= '0;
			v_u1    <= 1'b0;
			v_u2    <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == SW_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			v_u1 <= ctl.rd_en;
			v_u2 <= v_u1;
		end
	end

	// Direction of the update is fixed by the target of the failed image.
	always_ff @(posedge clk) begin
		if (start && state_q == SW_IDLE) begin
			positive_q <= positive;
		end
	end

	// Step size gamma times pixel, rounded half up to Q.16.
	always_comb begin
		scaled = gamma * i_rdata + SCALE_W'(128);
	end

	always_ff @(posedge clk) begin
		a_u1     <= cnt_q;
		a_u2     <= a_u1;
		delta_u2 <= scaled[SCALE_W-1:PIX_W];
		w_u2     <= w_rdata;
	end

	// Move the weight and clamp it to the signed weight range.
	always_comb begin
		if (positive_q) begin
			upd = (W_W+1)'(w_u2) + $signed({1'b0, (W_W)'(delta_u2)});
		end else begin
			upd = (W_W+1)'(w_u2) - $signed({1'b0, (W_W)'(delta_u2)});
		end
		if (upd[W_W] != upd[W_W-1]) begin
			wr_data = upd[W_W] ? W_MIN : W_MAX;
		end else begin
			wr_data = upd[W_W-1:0];
		end
		wr_addr = a_u2;
	end

endmodule

// ===== sv/pct_ofifo.sv =====
module pct_ofifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  pct_pkg::res_t                 push_data,
	input  logic                          pop,
	output logic                          not_empty,
	output pct_pkg::res_t                 head,
	output logic [pct_pkg::OFIFO_CW-1:0]  count
);
	import pct_pkg::*;

	res_t                entry_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OFIFO_CW-1:0] count_q;
	logic                do_pop;

	always_comb begin
		not_empty = (count_q != '0);
		do_pop    = pop && not_empty;
		head      = entry_q[rd_ptr_q];
		count     = count_q;
	end

	// Pointers and fill level; room is guaranteed by the input credit check.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + OFIFO_CW'(push) - OFIFO_CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== sv/perceptron_classify_train_unit.sv =====
// Perceptron classifier and trainer. Weights (signed Q7.16) are written with command 0 and read
// back with command 3; pixels (Q0.8) stream in with command 1 (classify) or 2 (train) and are
// multiply-accumulated against the weight memory, one word per cycle while the input is not
// stalled, with the result word passing through the accumulate pipeline and the output queue.
// After a training image's last pixel the input stalls until its decision is known; on a
// mistake the update sequencer then walks the weight and image memories, one position per
// cycle, and the input is held until the sweep has drained. Both memories hold garbage after
// reset until written, and there is no clearing pass. The learning rate sits at APB byte
// address 0, reset value 655.
module perceptron_classify_train_unit #(
	parameter int NUM_PIXELS = 784
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// index[9:0], weight_value[33:10], pixel[41:34], target_positive[42], zeros above.
	input  logic [47:0] s_tdata,
	// command[1:0].
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_weight[23:0], predicted_positive[24], mistake[25], zeros above.
	output logic [31:0] m_tdata,
	// result_kind[0].
	output logic        m_tuser,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pct_pkg::*;

	localparam int AW  = $clog2(NUM_PIXELS);
	localparam int IXW = ((AW > IDX_W) ? AW : IDX_W) + 1;

	logic [GAMMA_W-1:0]    gamma_q;
	logic signed [W_W-1:0] wmem [NUM_PIXELS];
	logic [PIX_W-1:0]      imem [NUM_PIXELS];
	logic signed [W_W-1:0] wmem_rd_q;
	logic [PIX_W-1:0]      imem_rd_q;

	cmd_t                  cmd;
	logic [IXW-1:0]        idx_ext;
	logic [AW-1:0]         in_addr;
	logic                  in_range;
	logic                  s_fire;
	logic                  cfg_hit;

	logic                  mac_push;
	res_t                  mac_res;
	mac_stat_t             mac_stat;
	logic [1:0]            inflight;

	sweep_ctl_t            sw_ctl;
	logic [AW-1:0]         sw_rd_addr, sw_wr_addr;
	logic signed [W_W-1:0] sw_wr_data;

	logic                  w_we;
	logic [AW-1:0]         w_waddr, w_raddr;
	logic signed [W_W-1:0] w_wdata;

	res_t                  head;
	logic [OFIFO_CW-1:0]   fifo_count;
	logic [OFIFO_CW-1:0]   credit_used;

	// Input word decode.
	always_comb begin
		cmd      = cmd_t'(s_tuser);
		idx_ext  = IXW'(s_tdata[IDX_W-1:0]);
		in_addr  = idx_ext[AW-1:0];
		in_range = idx_ext < IXW'(NUM_PIXELS);
	end

	// Accept only when the queue can take all results in flight and no hold or sweep is on.
	always_comb begin
		credit_used = fifo_count + OFIFO_CW'(inflight);
		s_tready    = (credit_used < OFIFO_CW'(OFIFO_DEPTH)) && !mac_stat.hold && !sw_ctl.busy;
		s_fire      = s_tvalid && s_tready;
	end

	// Configuration register.
	always_comb begin
		cfg_hit = (paddr[2] == 1'b0);
		pready  = 1'b1;
		prdata  = cfg_hit ? 32'(gamma_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_RESET;
		end else if (psel && penable && pwrite && pready && cfg_hit) begin
			gamma_q <= pwdata[GAMMA_W-1:0];
		end
	end

	// Weight memory ports: the update sequencer owns them while it runs.
	always_comb begin
		w_raddr = sw_ctl.rd_en ? sw_rd_addr : in_addr;
		if (sw_ctl.wr_en) begin
			w_we    = 1'b1;
			w_waddr = sw_wr_addr;
			w_wdata = sw_wr_data;
		end else begin
			w_we    = s_fire && cmd == CMD_WRITE && in_range;
			w_waddr = in_addr;
			w_wdata = s_tdata[IDX_W +: W_W];
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) wmem[w_waddr] <= w_wdata;
		wmem_rd_q <= wmem[w_raddr];
	end

	// Image memory keeps the training pixels for the update.
	always_ff @(posedge clk) begin
		if (s_fire && cmd == CMD_TRAIN && in_range) begin
			imem[in_addr] <= s_tdata[IDX_W+W_W +: PIX_W];
		end
		imem_rd_q <= imem[sw_rd_addr];
	end

	pct_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_fire && cmd != CMD_WRITE),
		.in_cmd    (cmd),
		.in_pixel  (s_tdata[IDX_W+W_W +: PIX_W]),
		.in_target (s_tdata[IDX_W+W_W+PIX_W]),
		.in_last   (s_tlast),
		.in_range  (in_range),
		.w_rdata   (wmem_rd_q),
		.push      (mac_push),
		.res       (mac_res),
		.stat      (mac_stat),
		.inflight  (inflight)
	);

	pct_sweep #(
		.NUM_PIXELS (NUM_PIXELS),
		.AW         (AW)
	) u_sweep (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mac_stat.start),
		.positive (mac_stat.positive),
		.gamma    (gamma_q),
		.w_rdata  (wmem_rd_q),
		.i_rdata  (imem_rd_q),
		.ctl      (sw_ctl),
		.rd_addr  (sw_rd_addr),
		.wr_addr  (sw_wr_addr),
		.wr_data  (sw_wr_data)
	);

	pct_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (mac_push),
		.push_data (mac_res),
		.pop       (m_tready),
		.not_empty (m_tvalid),
		.head      (head),
		.count     (fifo_count)
	);

	// Result word packing.
	always_comb begin
		m_tuser = head.result_kind;
		m_tdata = {6'b0, head.mistake, head.predicted_positive, head.read_weight};
	end

endmodule

// ===== sv/pct_sva.sv =====
module pct_sva (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic        pready,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);
	import pct_pkg::*;
	`include "perceptron_classify_train_unit_defines.svh"

	// A stalled result word holds still.
	`PCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

	// A readback carries no decision bits, and a decision carries no weight.
	`PCT_ASSERT_NOW(a_kind_fields, m_tvalid, (m_tuser == KIND_READBACK) ? (m_tdata[25:24] == 2'b00) : (m_tdata[23:0] == 24'd0), "result fields do not match the result kind")

	// The last pixel of a training image stalls the input until its decision is known.
	`PCT_ASSERT_NEXT(a_train_stall, s_tvalid && s_tready && s_tlast && s_tuser == CMD_TRAIN, !s_tready, "input taken right after a training image ended")

	// A learning-rate write reads back on the next cycle.
	`PCT_ASSERT_NEXT(a_cfg_readback, psel && penable && pwrite && pready && paddr[2] == 1'b0, (paddr[2] != 1'b0) || (prdata == {16'b0, $past(pwdata[15:0])}), "learning rate did not read back as written")

endmodule

bind perceptron_classify_train_unit pct_sva u_sva (.*);

// ===== tb/tb_perceptron_classify_train_unit.sv =====
module tb_perceptron_classify_train_unit;
	import pct_pkg::*;

	localparam int NUM_PIX = 32;
	localparam int IDX_TOP = (1 << IDX_W) - 1;
	localparam logic signed [W_W-1:0] W_MAX = 24'sh7FFFFF;
	localparam logic signed [W_W-1:0] W_MIN = 24'sh800000;
	localparam longint SUM_MAX = 64'sd2199023255551;
	localparam longint SUM_MIN = -64'sd2199023255552;
	localparam logic [2:0] ADDR_LEARNING_RATE = 3'd0;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = NUM_PIX + 64;
	localparam int WATCHDOG_LIMIT = 5000;

	// Mirror of the weight and image memories, the running sum and the step size.
	class perceptron_predictor;
		int               weight_mem[NUM_PIX];
		bit [PIX_W-1:0]   image_mem[NUM_PIX];
		longint           dot_sum;
		bit [GAMMA_W-1:0] gamma;
		res_t             results_due[$];
		int               mismatches;

		function new();
			dot_sum = 0;
			gamma = GAMMA_RESET;
			mismatches = 0;
		endfunction

		function int clamp_weight(longint v);
			if (v > longint'(W_MAX)) return int'(W_MAX);
			if (v < longint'(W_MIN)) return int'(W_MIN);
			return int'(v);
		endfunction

		// Moves every weight by the step size times its stored pixel, rounded half up.
		function void apply_update(bit upward);
			longint delta;
			for (int i = 0; i < NUM_PIX; i++) begin
				delta = (longint'(gamma) * longint'(image_mem[i]) + 128) >>> 8;
				weight_mem[i] = clamp_weight(upward ? weight_mem[i] + delta
					: weight_mem[i] - delta);
			end
		endfunction

		// Updates the mirror for one accepted word and queues the result it causes.
		function void note_word(cmd_t cmd, logic [IDX_W-1:0] idx, logic signed [W_W-1:0] wv,
				logic [PIX_W-1:0] pix, logic tgt, logic is_last);
			bit     in_range;
			bit     positive;
			bit     missed;
			longint acc;
			res_t   r;
			in_range = idx < NUM_PIX;
			r = '0;
			case (cmd)
				CMD_WRITE: begin
					if (in_range) weight_mem[idx] = int'(wv);
				end
				CMD_READ: begin
					r.result_kind = KIND_READBACK;
					r.read_weight = in_range ? weight_mem[idx][W_W-1:0] : '0;
					results_due.push_back(r);
				end
				default: begin
					if (in_range) begin
						acc = dot_sum + longint'(weight_mem[idx]) * longint'(pix);
						if (acc > SUM_MAX) acc = SUM_MAX;
						if (acc < SUM_MIN) acc = SUM_MIN;
						dot_sum = acc;
						if (cmd == CMD_TRAIN) image_mem[idx] = pix;
					end
					if (is_last) begin
						positive = dot_sum >= 0;
						dot_sum = 0;
						missed = (cmd == CMD_TRAIN) && (positive != tgt);
						if (missed) apply_update(tgt);
						r.result_kind = KIND_DECISION;
						r.predicted_positive = positive;
						r.mistake = missed;
						results_due.push_back(r);
					end
				end
			endcase
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		// Compares one accepted result word with the oldest one still due.
		function void check_result(res_t got);
			res_t want;
			if (results_due.size() == 0) begin
				$display("%0t: result expected none, actual %h", $time, got);
				mismatches++;
				return;
			end
			want = results_due.pop_front();
			compare_field("result_kind", want.result_kind, got.result_kind);
			compare_field("read_weight", want.read_weight, got.read_weight);
			compare_field("predicted_positive", want.predicted_positive,
				got.predicted_positive);
			compare_field("mistake", want.mistake, got.mistake);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	perceptron_predictor model = new();
	bit idling_on = 1'b0;
	bit long_hold_req = 1'b0;
	int hold_left = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	perceptron_classify_train_unit #(
		.NUM_PIXELS(NUM_PIX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 5);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Every accepted result word is checked against the predictor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			model.check_result(res_t'{mistake: m_tdata[25], predicted_positive: m_tdata[24],
				read_weight: m_tdata[23:0], result_kind: m_tuser});
	end

	// Watchdog on cycles in which no word and no register access goes through.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Offers one word at a falling edge and returns at the falling edge after it is taken.
	task automatic send_word(cmd_t cmd, logic [IDX_W-1:0] idx, logic signed [W_W-1:0] wv,
			logic [PIX_W-1:0] pix, logic tgt, logic is_last);
		int gap;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, tgt, pix, wv, idx};
		s_tuser  <= cmd;
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
		model.note_word(cmd, idx, wv, pix, tgt, is_last);
		@(negedge clk);
	endtask

	// Setup and access phases of one register transfer.
	task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] wdata,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic void check_rate(logic [31:0] rd);
		if (rd !== 32'(model.gamma)) begin
			$display("%0t: learning_rate expected %0h, actual %0h", $time, model.gamma, rd);
			model.mismatches++;
		end
	endfunction

	// Stops offering, then waits until all results are in and a full update sweep
	// could have finished.
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (model.results_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_learning_rate(logic [GAMMA_W-1:0] rate);
		logic [31:0] rd;
		settle_idle();
		apb_access(1'b1, ADDR_LEARNING_RATE, 32'(rate), rd);
		model.gamma = rate;
		apb_access(1'b0, ADDR_LEARNING_RATE, '0, rd);
		check_rate(rd);
	endtask

	function automatic logic [IDX_W-1:0] pick_index();
		if ($urandom_range(0, 9) == 0) return $urandom_range(NUM_PIX, IDX_TOP);
		return $urandom_range(0, NUM_PIX - 1);
	endfunction

	function automatic logic signed [W_W-1:0] pick_weight();
		case ($urandom_range(0, 11))
			0: return W_MAX;
			1: return W_MIN;
			2: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Random traffic: mostly whole images of random content, some weight writes and reads,
	// and now and then a pixel of the other mode inside an image.
	task automatic run_random(int n_words, bit allow_idling);
		int   sent;
		int   len;
		int   kind;
		cmd_t mode;
		cmd_t cmd;
		sent = 0;
		while (sent < n_words) begin
			if (!allow_idling)
				idling_on = 1'b0;
			else if ($urandom_range(0, 7) == 0)
				idling_on = !idling_on;
			kind = $urandom_range(0, 19);
			if (kind < 2) begin
				send_word(CMD_WRITE, pick_index(), pick_weight(), $urandom, $urandom, $urandom);
				sent++;
			end else if (kind < 4) begin
				send_word(CMD_READ, pick_index(), $urandom, $urandom, $urandom, $urandom);
				sent++;
			end else begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				mode = $urandom_range(0, 1) ? CMD_TRAIN : CMD_CLASSIFY;
				for (int k = 0; k < len; k++) begin
					cmd = mode;
					if (k != len - 1 && $urandom_range(0, 9) == 0)
						cmd = (mode == CMD_TRAIN) ? CMD_CLASSIFY : CMD_TRAIN;
					send_word(cmd, pick_index(), $urandom, pick_pixel(), $urandom, k == len - 1);
				end
				sent += len;
			end
		end
	endtask

	initial begin : stimulus
		logic [31:0] rd;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The step size comes out of reset at its default.
		apb_access(1'b0, ADDR_LEARNING_RATE, '0, rd);
		check_rate(rd);
		idling_on = 1'b1;

		// Fill both memories so that no read ever touches an unwritten entry.
		for (int i = 0; i < NUM_PIX; i++)
			send_word(CMD_WRITE, i, $urandom, $urandom, $urandom, $urandom);
		for (int i = 0; i < NUM_PIX; i++)
			send_word(CMD_TRAIN, i, $urandom, $urandom, $urandom, i == NUM_PIX - 1);

		// Out-of-range writes and reads, and readback of the extremes.
		send_word(CMD_WRITE, 0, W_MAX, '0, 1'b0, 1'b0);
		send_word(CMD_WRITE, 1, W_MIN, '0, 1'b0, 1'b0);
		send_word(CMD_WRITE, IDX_TOP, 24'h123456, '1, 1'b1, 1'b1);
		send_word(CMD_READ, IDX_TOP, '0, '0, 1'b0, 1'b0);
		send_word(CMD_READ, NUM_PIX, '0, '0, 1'b0, 1'b1);
		send_word(CMD_READ, 0, '0, '0, 1'b0, 1'b0);
		send_word(CMD_READ, 1, '0, '0, 1'b0, 1'b0);
		send_word(CMD_READ, NUM_PIX - 1, '0, '0, 1'b0, 1'b0);

		// Classification: ignored out-of-range pixel, zero sum counted positive,
		// and a negative sum.
		send_word(CMD_CLASSIFY, NUM_PIX, '0, '1, 1'b0, 1'b0);
		send_word(CMD_CLASSIFY, 0, '0, 8'd1, 1'b0, 1'b0);
		send_word(CMD_CLASSIFY, 1, '0, '0, 1'b0, 1'b1);
		send_word(CMD_CLASSIFY, 1, '0, '1, 1'b0, 1'b1);
		send_word(CMD_CLASSIFY, 900, '0, '1, 1'b0, 1'b1);

		// Writes and reads with the last flag set do not end an open image.
		send_word(CMD_CLASSIFY, 0, '0, '1, 1'b0, 1'b0);
		send_word(CMD_WRITE, 5, -24'sd1, '1, 1'b1, 1'b1);
		send_word(CMD_READ, 5, '0, '1, 1'b1, 1'b1);
		send_word(CMD_CLASSIFY, 1, '0, '1, 1'b0, 1'b1);

		// Training: a downward update, an upward update, and a hit with no update.
		send_word(CMD_TRAIN, 0, '0, '1, 1'b0, 1'b1);
		send_word(CMD_TRAIN, 1, '0, '1, 1'b1, 1'b1);
		send_word(CMD_TRAIN, 2, '0, '0, 1'b1, 1'b1);

		run_random(130, 1'b1);

		// Largest step: weights clip at both ends; the result side holds off once for long.
		set_learning_rate('1);
		send_word(CMD_WRITE, 0, W_MAX, '0, 1'b0, 1'b0);
		send_word(CMD_WRITE, 1, W_MIN, '0, 1'b0, 1'b0);
		send_word(CMD_TRAIN, 0, '0, '1, 1'b0, 1'b0);
		send_word(CMD_TRAIN, 1, '0, '1, 1'b1, 1'b1);
		send_word(CMD_READ, 0, '0, '0, 1'b0, 1'b0);
		send_word(CMD_WRITE, 1, W_MIN, '0, 1'b0, 1'b0);
		send_word(CMD_TRAIN, 0, '0, '1, 1'b0, 1'b1);
		send_word(CMD_READ, 1, '0, '0, 1'b0, 1'b0);
		long_hold_req = 1'b1;
		run_random(130, 1'b1);

		// Zero step: mistakes are flagged but weights stay put.
		set_learning_rate('0);
		run_random(110, 1'b1);

		set_learning_rate($urandom);
		run_random(130, 1'b1);

		// Smallest nonzero step, with both sides running flat out.
		set_learning_rate(16'd1);
		run_random(130, 1'b0);

		s_tvalid <= 1'b0;
		while (model.results_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (model.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== perceptron_classify_train_unit.f =====
+incdir+sv
sv/pct_pkg.sv
sv/pct_mac.sv
sv/pct_sweep.sv
sv/pct_ofifo.sv
sv/perceptron_classify_train_unit.sv
sv/pct_sva.sv
tb/tb_perceptron_classify_train_unit.sv
